// ----- sv/iq4nl_pkg.sv -----
package iq4nl_pkg;

  localparam int unsigned NumPairs = 16;
  localparam int unsigned PairIdxW = 4;

  typedef struct packed {
    logic [63:0] quants_second;
    logic [63:0] quants_first;
    logic [15:0] scale_half;
  } iq4nl_in_t;

  typedef struct packed {
    logic        last_of_block;
    logic [31:0] value_second;
    logic [31:0] value_first;
    logic [3:0]  pair_index;
  } iq4nl_out_t;

  typedef enum logic [1:0] {
    SC_ZERO = 2'd0,
    SC_FIN  = 2'd1,
    SC_INF  = 2'd2,
    SC_NAN  = 2'd3
  } iq4nl_kind_t;

  function automatic logic [6:0] level_mag(input logic [3:0] code);
    logic [6:0] m;
    unique case (code)
      4'd0: m = 7'd127;
      4'd1: m = 7'd104;
      4'd2: m = 7'd83;
      4'd3: m = 7'd65;
      4'd4: m = 7'd49;
      4'd5: m = 7'd35;
      4'd6: m = 7'd22;
      4'd7: m = 7'd10;
      4'd8: m = 7'd1;
      4'd9: m = 7'd13;
      4'd10: m = 7'd25;
      4'd11: m = 7'd38;
      4'd12: m = 7'd53;
      4'd13: m = 7'd69;
      4'd14: m = 7'd89;
      default: m = 7'd113;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] lead_pos(input logic [17:0] p);
    logic [4:0] t;
    t = 5'd0;
    for (int i = 0; i < 18; i++) begin
      if (p[i]) begin
        t = 5'(i);
      end
    end
    return t;
  endfunction

endpackage

// ----- sv/iq4_nl_block_dequantizer.sv -----
// IQ4_NL block dequantizer.
// A request carries one 32-weight block: a binary16 scale and sixteen code
// bytes. It is taken at a rising edge where in_start is high and in_busy is
// low. The block then emits sixteen results, one per cycle, for bytes 0 to
// 15 in order; each result shows binary32 values for elements j and j+16
// and is marked by out_valid for exactly one cycle. last_of_block is set on
// byte 15. The receiver cannot stall the block.
// A new request waits until the previous block is issued, at one byte
// pair per cycle; in_busy stays high while bytes remain to be issued and
// drops in the cycle that issues byte 15, so a request taken at that edge
// follows the previous block with no gap.
// The byte stream runs through a four-stage pipeline (code lookup, mantissa
// product, leading-one search, normalization and packing).
// Reset clears the issue counter and all pipeline valid bits and holds
// in_busy high; any results in flight are dropped.
module iq4_nl_block_dequantizer
  import iq4nl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_start,
  output logic       in_busy,
  input  iq4nl_in_t  in_req,
  output logic       out_valid,
  output iq4nl_out_t out_res
);

  logic              act_r;
  logic [PairIdxW-1:0] cnt_r;
  logic [15:0]       sc_r;
  logic [127:0]      q_r;

  assign in_busy = !rst_n || (act_r && (cnt_r != PairIdxW'(NumPairs - 1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
    end else if (in_start && !in_busy) begin
      act_r <= 1'b1;
      cnt_r <= '0;
    end else if (act_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == PairIdxW'(NumPairs - 1)) begin
        act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_start && !in_busy) begin
      sc_r <= in_req.scale_half;
      q_r  <= {in_req.quants_second, in_req.quants_first};
    end
  end

  logic [7:0] byte_sel;
  assign byte_sel = q_r[{cnt_r, 3'b000} +: 8];

  // Stage 1: decode the scale and look up both levels.
  logic        v1_r;
  logic [3:0]  idx1_r;
  iq4nl_kind_t kind1_r;
  logic        hs1_r;
  logic [10:0] m1_r;
  logic [5:0]  e1_r;
  logic [9:0]  hf1_r;
  logic [6:0]  mg1_r [2];
  logic [1:0]  ng1_r;

  logic [4:0] hexp;
  logic [9:0] hfrac;
  assign hexp  = sc_r[14:10];
  assign hfrac = sc_r[9:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r   <= cnt_r;
    hs1_r    <= sc_r[15];
    hf1_r    <= hfrac;
    mg1_r[0] <= level_mag(byte_sel[3:0]);
    mg1_r[1] <= level_mag(byte_sel[7:4]);
    ng1_r    <= {~byte_sel[7], ~byte_sel[3]};
    if (hexp == 5'h1F) begin
      kind1_r <= (hfrac != 10'd0) ? SC_NAN : SC_INF;
    end else if (hexp == 5'd0 && hfrac == 10'd0) begin
      kind1_r <= SC_ZERO;
    end else begin
      kind1_r <= SC_FIN;
    end
    if (hexp == 5'd0) begin
      m1_r <= {1'b0, hfrac};
      e1_r <= 6'd1;
    end else begin
      m1_r <= {1'b1, hfrac};
      e1_r <= {1'b0, hexp};
    end
  end

  // Stage 2: mantissa products.
  logic        v2_r;
  logic [3:0]  idx2_r;
  iq4nl_kind_t kind2_r;
  logic        hs2_r;
  logic [5:0]  e2_r;
  logic [9:0]  hf2_r;
  logic [17:0] p2_r [2];
  logic [1:0]  ng2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    idx2_r  <= idx1_r;
    kind2_r <= kind1_r;
    hs2_r   <= hs1_r;
    e2_r    <= e1_r;
    hf2_r   <= hf1_r;
    ng2_r   <= ng1_r;
    for (int k = 0; k < 2; k++) begin
      p2_r[k] <= 18'(m1_r * mg1_r[k]);
    end
  end

  // Stage 3: find the leading one.
  logic        v3_r;
  logic [3:0]  idx3_r;
  iq4nl_kind_t kind3_r;
  logic        hs3_r;
  logic [5:0]  e3_r;
  logic [9:0]  hf3_r;
  logic [17:0] p3_r [2];
  logic [4:0]  t3_r [2];
  logic [1:0]  ng3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    idx3_r  <= idx2_r;
    kind3_r <= kind2_r;
    hs3_r   <= hs2_r;
    e3_r    <= e2_r;
    hf3_r   <= hf2_r;
    ng3_r   <= ng2_r;
    for (int k = 0; k < 2; k++) begin
      p3_r[k] <= p2_r[k];
      t3_r[k] <= lead_pos(p2_r[k]);
    end
  end

  // Stage 4: normalize and pack.
  logic [31:0] val [2];

  always_comb begin
    logic [40:0] sh;
    logic [7:0]  ex;
    logic        sg;
    for (int k = 0; k < 2; k++) begin
      sg = hs3_r ^ ng3_r[k];
      sh = 41'({23'd0, p3_r[k]} << (5'd23 - t3_r[k]));
      // Biased exponent: (hexp - 25) + top + 127, subnormal uses hexp of 1.
      ex = 8'(e3_r) + 8'(t3_r[k]) + 8'd102;
      unique case (kind3_r)
        SC_ZERO: val[k] = {sg, 31'd0};
        SC_INF:  val[k] = {sg, 8'hFF, 23'd0};
        SC_NAN:  val[k] = {hs3_r, 8'hFF, 1'b1, hf3_r[8:0], 13'd0};
        default: val[k] = {sg, ex, sh[22:0]};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    out_res.pair_index    <= idx3_r;
    out_res.value_first   <= val[0];
    out_res.value_second  <= val[1];
    out_res.last_of_block <= (idx3_r == PairIdxW'(NumPairs - 1));
  end

endmodule

// ----- sv/iq4_nl_block_dequantizer_chk.sv -----
module iq4_nl_block_dequantizer_chk
  import iq4nl_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_start,
  input logic       in_busy,
  input logic       out_valid,
  input iq4nl_out_t out_res
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_start && !in_busy) |=> in_busy)
    else $error("busy not raised after a request");

  a_last_is_fifteen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.last_of_block) |-> (out_res.pair_index == 4'd15))
    else $error("last flag on wrong byte");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.last_of_block) |=>
      (out_valid && out_res.pair_index == $past(out_res.pair_index) + 4'd1))
    else $error("result stream broke within a block");

  a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_start && !in_busy) |-> ##5 (out_valid && out_res.pair_index == 4'd0))
    else $error("first result late");

endmodule

bind iq4_nl_block_dequantizer iq4_nl_block_dequantizer_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_start(in_start), .in_busy(in_busy),
  .out_valid(out_valid), .out_res(out_res)
);
